// File: sv/mssm_pkg.sv
// ----------------------------------------------------------------------------
// mssm_pkg: shared types and constants for the stack median selector
// Holds the payload widths, the order key function and the cell control struct.
// ----------------------------------------------------------------------------
package mssm_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned DEPTH_W  = 6;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic                shift_en;   // insert the new sample this cycle
    logic [SAMPLE_W-1:0] key;        // order key of the new sample
    logic [SAMPLE_W-1:0] sample;     // raw bits of the new sample
  } cell_ctrl_t;

  // Map an IEEE pattern to an unsigned key that sorts by value, -0 below +0
  function automatic logic [SAMPLE_W-1:0] order_key(input logic [SAMPLE_W-1:0] bits);
    logic [SAMPLE_W-1:0] k;
    if (bits[SAMPLE_W-1]) begin
      k = ~bits;
    end else begin
      k = bits | {1'b1, {(SAMPLE_W-1){1'b0}}};
    end
    return k;
  endfunction

endpackage

// File: sv/mssm_stream_if.sv
// ----------------------------------------------------------------------------
// mssm_stream_if: valid/ready channel
// Carries one request payload of parameterized width.
// ----------------------------------------------------------------------------
interface mssm_stream_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/mssm_cell.sv
// ----------------------------------------------------------------------------
// mssm_cell: one slot of the insertion chain
// Holds one sorted sample; takes the new sample or its left neighbor's on insert.
// ----------------------------------------------------------------------------
module mssm_cell (
  input  logic                         clk,
  input  mssm_pkg::cell_ctrl_t         ctrl,
  input  logic                         occupied,     // slot holds a sample of this pixel
  input  logic                         left_greater, // left neighbor moves right
  input  logic [mssm_pkg::SAMPLE_W-1:0] left_bits,
  output logic                         greater,      // this slot's key above new key
  output logic [mssm_pkg::SAMPLE_W-1:0] bits
);

  logic [mssm_pkg::SAMPLE_W-1:0] bits_r;
  logic [mssm_pkg::SAMPLE_W-1:0] bits_nxt;

  assign greater = occupied && (mssm_pkg::order_key(bits_r) > ctrl.key);
  assign bits    = bits_r;

  // Shift from left when it is larger, drop the new sample here at the boundary
  always_comb begin
    bits_nxt = bits_r;
    if (ctrl.shift_en) begin
      if (left_greater) begin
        bits_nxt = left_bits;
      end else if (greater || !occupied) begin
        bits_nxt = ctrl.sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
  end

endmodule

// File: sv/masked_stack_median_select.sv
// Result: the result of a pixel's last sample is registered and offered in the cycle after acceptance.
// Throughput: one sample per cycle while the result register is free or being drained;
//   each sample enters the cell chain in the cycle it is accepted; the result register frees on out_ready.
// Reset: rst_n (synchronous, active low) clears the count, the depth (to 1) and
//   the output valid; the cell contents are left as they are.
// ----------------------------------------------------------------------------
// masked_stack_median_select: streaming per-pixel median of an image stack
// Insertion-sorts each pixel's samples in a chain of cells and emits the median (zero if the last mask bit is 0).
// ----------------------------------------------------------------------------
module masked_stack_median_select #(
  parameter int unsigned MAX_DEPTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  mssm_stream_if.sink   in_ch,
  mssm_stream_if.sink   cfg_ch,
  mssm_stream_if.source out_ch
);

  localparam int unsigned SW  = mssm_pkg::SAMPLE_W;
  localparam int unsigned DW  = mssm_pkg::DEPTH_W;
  localparam int unsigned CW  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [DW-1:0] depth_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  logic [SW-1:0] out_bits_r;

  mssm_pkg::cell_ctrl_t ctrl;
  logic [MAX_DEPTH-1:0] occ, gt;
  logic [SW-1:0]        cell_bits [MAX_DEPTH];

  logic          in_fire, cfg_fire, last;
  logic [SW-1:0] in_sample;
  logic          in_mask;
  logic [CW-1:0] eff_depth, cnt_clamp, new_count;
  logic [CW-1:0] rank;
  logic [SW-1:0] sel_bits;

  assign in_sample = in_ch.data[SW:1];
  assign in_mask   = in_ch.data[0];

  // Accept a sample while the result register is free or being drained
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  // Clamp depth into 1..MAX_DEPTH
  always_comb begin
    if (depth_r == '0) begin
      eff_depth = CW'(1);
    end else if (32'(depth_r) > MAX_DEPTH) begin
      eff_depth = CW'(MAX_DEPTH);
    end else begin
      eff_depth = CW'(depth_r);
    end
  end

  assign cnt_clamp = (32'(count_r) >= MAX_DEPTH) ? CW'(MAX_DEPTH - 1) : count_r;
  assign new_count = cnt_clamp + CW'(1);
  assign last      = new_count >= eff_depth;

  assign ctrl.shift_en = in_fire;
  assign ctrl.key      = mssm_pkg::order_key(in_sample);
  assign ctrl.sample   = in_sample;

  // Build the chain of cells
  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    logic          lg;
    logic [SW-1:0] lb;
    assign occ[i] = 32'(i) < 32'(cnt_clamp);
    if (i == 0) begin : g_first
      assign lg = 1'b0;
      assign lb = in_sample;
    end else begin : g_rest
      assign lg = gt[i-1];
      assign lb = cell_bits[i-1];
    end
    mssm_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .occupied     (occ[i]),
      .left_greater (lg),
      .left_bits    (lb),
      .greater      (gt[i]),
      .bits         (cell_bits[i])
    );
  end

  // Pick the median rank from the freshly inserted list
  always_comb begin
    rank = eff_depth >> 1;
    if (rank >= new_count) begin
      rank = new_count - CW'(1);
    end
  end

  // Post-insert view of slot rank: shifted, new sample, or unchanged
  always_comb begin
    logic [IW-1:0] r;
    r = rank[IW-1:0];
    if (r != '0 && gt[r - IW'(1)]) begin
      sel_bits = cell_bits[r - IW'(1)];
    end else if (gt[r] || !occ[r]) begin
      sel_bits = in_sample;
    end else begin
      sel_bits = cell_bits[r];
    end
  end

  // Advance count, clear it after a pixel's last sample, drop pixel on config write
  always_comb begin
    count_nxt = count_r;
    if (in_fire) begin
      count_nxt = last ? '0 : new_count;
    end
    if (cfg_fire) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= DW'(1);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_fire) begin
        depth_r <= cfg_ch.data[DW-1:0];
      end
      if (in_fire && last) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (in_fire && last) begin
      out_bits_r <= in_mask ? sel_bits : '0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_bits_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) < MAX_DEPTH)
    else $error("sample count beyond chain length");
  a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last) |=> out_valid_r)
    else $error("result missing after last sample");
  a_count_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last) |=> (count_r == '0))
    else $error("count not cleared at pixel end");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(out_bits_r))
    else $error("result changed while stalled");
`endif

endmodule
